// ===== rtl/rpc_auth_credential_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// RPC credential parser assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef RPC_AUTH_CREDENTIAL_PARSER_CORE_ASSERT_SVH
`define RPC_AUTH_CREDENTIAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPCAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPCAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rpcac_pkg.sv =====
// ----------------------------------------------------------------------------
// RPC credential parser package
// Phase, status and kind codes, limits and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpcac_pkg;

	localparam logic [10:0] MAX_BUFFER_WORDS = 11'd1024;
	localparam logic [30:0] MAX_NAME_WORDS   = 31'd64;
	localparam logic [31:0] MAX_GROUPS       = 32'd16;
	localparam logic [10:0] MIN_AVAIL_WORDS  = 11'd3;
	localparam logic [31:0] NAME_TAIL_WORDS  = 32'd3;
	localparam logic [32:0] GROUP_TAIL_WORDS = 33'd2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_STAMP = 4'd1,
		PH_MLEN  = 4'd2,
		PH_NAME  = 4'd3,
		PH_UID   = 4'd4,
		PH_GID   = 4'd5,
		PH_GLEN  = 4'd6,
		PH_GRP   = 4'd7,
		PH_VFL   = 4'd8,
		PH_VLEN  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_GARBAGE = 2'd1,
		ST_BADCRED = 2'd2,
		ST_BADVERF = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_UID     = 2'd0,
		KIND_GID     = 2'd1,
		KIND_GROUP   = 2'd2,
		KIND_VERDICT = 2'd3
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [31:0] value;
		status_t     status;
		logic [10:0] remaining_len;
		logic [4:0]  group_count;
	} res_t;

endpackage

// ===== rtl/rpcac_fsm.sv =====
// ----------------------------------------------------------------------------
// RPC credential parser phase engine
// Holds the parse state and turns one registered word into at most one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rpc_auth_credential_parser_core_assert.svh"

module rpcac_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [31:0]       word,
	input  logic              first,
	input  logic              flavor_null,
	input  logic [10:0]       avail_len,
	output rpcac_pkg::res_t   res
);
	import rpcac_pkg::*;

	phase_t      phase_q, phase_d;
	logic [10:0] words_left_q, words_left_d;
	logic [6:0]  skip_count_q, skip_count_d;
	logic [4:0]  groups_left_q, groups_left_d;
	logic [4:0]  groups_seen_q, groups_seen_d;
	logic        null_mode_q, null_mode_d;

	logic [10:0] avl;
	logic [32:0] name_round;
	logic [30:0] name_words;
	logic [31:0] name_need;
	logic [32:0] group_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			words_left_q  <= '0;
			skip_count_q  <= '0;
			groups_left_q <= '0;
			groups_seen_q <= '0;
			null_mode_q   <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			words_left_q  <= words_left_d;
			skip_count_q  <= skip_count_d;
			groups_left_q <= groups_left_d;
			groups_seen_q <= groups_seen_d;
			null_mode_q   <= null_mode_d;
		end
	end

	always_comb begin
		avl        = (avail_len > MAX_BUFFER_WORDS) ? MAX_BUFFER_WORDS : avail_len;
		name_round = {1'b0, word} + 33'd3;
		name_words = name_round[32:2];
		name_need  = {1'b0, name_words} + NAME_TAIL_WORDS;
		group_need = {1'b0, word} + GROUP_TAIL_WORDS;

		phase_d       = phase_q;
		words_left_d  = words_left_q;
		skip_count_d  = skip_count_q;
		groups_left_d = groups_left_q;
		groups_seen_d = groups_seen_q;
		null_mode_d   = null_mode_q;

		res               = '0;
		res.kind          = KIND_UID;
		res.status        = ST_OK;
		res.value         = word;

		if (first) begin
			null_mode_d   = flavor_null;
			groups_seen_d = '0;
			groups_left_d = '0;
			skip_count_d  = '0;
			words_left_d  = '0;
			if (avl < MIN_AVAIL_WORDS) begin
				res.valid  = 1'b1;
				res.kind   = KIND_VERDICT;
				res.status = ST_GARBAGE;
				phase_d    = PH_IDLE;
			end else begin
				words_left_d = avl - MIN_AVAIL_WORDS;
				if (flavor_null) begin
					if (word != 32'd0) begin
						res.valid  = 1'b1;
						res.kind   = KIND_VERDICT;
						res.status = ST_BADCRED;
						phase_d    = PH_IDLE;
					end else begin
						phase_d = PH_VFL;
					end
				end else begin
					phase_d = PH_STAMP;
				end
			end
		end else begin
			unique case (phase_q)
				PH_STAMP: begin
					phase_d = PH_MLEN;
				end
				PH_MLEN: begin
					if (name_words > MAX_NAME_WORDS || name_need > {21'd0, words_left_q}) begin
						res.valid  = 1'b1;
						res.kind   = KIND_VERDICT;
						res.status = ST_BADCRED;
						phase_d    = PH_IDLE;
					end else begin
						words_left_d = words_left_q - name_need[10:0];
						skip_count_d = name_words[6:0];
						phase_d      = (name_words != '0) ? PH_NAME : PH_UID;
					end
				end
				PH_NAME: begin
					skip_count_d = skip_count_q - 7'd1;
					if (skip_count_d == '0) begin
						phase_d = PH_UID;
					end
				end
				PH_UID: begin
					res.valid = 1'b1;
					res.kind  = KIND_UID;
					phase_d   = PH_GID;
				end
				PH_GID: begin
					res.valid = 1'b1;
					res.kind  = KIND_GID;
					phase_d   = PH_GLEN;
				end
				PH_GLEN: begin
					if (word > MAX_GROUPS || group_need > {22'd0, words_left_q}) begin
						res.valid  = 1'b1;
						res.kind   = KIND_VERDICT;
						res.status = ST_BADCRED;
						phase_d    = PH_IDLE;
					end else begin
						words_left_d  = words_left_q - group_need[10:0];
						groups_left_d = word[4:0];
						groups_seen_d = '0;
						phase_d       = (word != 32'd0) ? PH_GRP : PH_VFL;
					end
				end
				PH_GRP: begin
					res.valid     = 1'b1;
					res.kind      = KIND_GROUP;
					groups_seen_d = groups_seen_q + 5'd1;
					groups_left_d = groups_left_q - 5'd1;
					if (groups_left_d == '0) begin
						phase_d = PH_VFL;
					end
				end
				PH_VFL: begin
					if (word != 32'd0) begin
						res.valid  = 1'b1;
						res.kind   = KIND_VERDICT;
						res.status = ST_BADVERF;
						phase_d    = PH_IDLE;
					end else begin
						phase_d = PH_VLEN;
					end
				end
				PH_VLEN: begin
					res.valid  = 1'b1;
					res.kind   = KIND_VERDICT;
					res.status = (word != 32'd0) ? ST_BADVERF : ST_OK;
					phase_d    = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (res.kind == KIND_VERDICT) begin
			res.value         = '0;
			res.group_count   = first ? 5'd0 : groups_seen_q;
			res.remaining_len = (res.status == ST_OK) ? words_left_q : 11'd0;
		end
	end

	`RPCAC_ASSERT_NOW(a_name_skip_nonzero, clk, arst_n, phase_q == PH_NAME,
		skip_count_q != 7'd0, "name phase entered with no words to skip")
	`RPCAC_ASSERT_NOW(a_groups_pending, clk, arst_n, phase_q == PH_GRP,
		groups_left_q != 5'd0, "group phase entered with no groups left")
	`RPCAC_ASSERT_NOW(a_groups_bounded, clk, arst_n, 1'b1,
		{27'd0, groups_seen_q} <= MAX_GROUPS, "group count exceeds limit")
	`RPCAC_ASSERT_NEXT(a_verdict_idles, clk, arst_n,
		step && res.valid && res.kind == KIND_VERDICT, phase_q == PH_IDLE,
		"parser not idle after a verdict")

endmodule

// ===== rtl/rpc_auth_credential_parser_core.sv =====
// One XDR word is taken per cycle and each word yields at most one result: a uid, a
// gid, a group id or the final verdict of the credential. A word is held in the input
// register and its result is then written into the result register when that is free or
// being taken, and the block sustains one word per cycle as long as results are taken;
// a stalled result holds the input register and stops new words.
// ----------------------------------------------------------------------------
// RPC Unix-style / null credential parser
// Input register, phase engine and result register for the word stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpc_auth_credential_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] word,
	input  logic        first,
	input  logic        flavor_null,
	input  logic [10:0] avail_len,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [31:0] value,
	output logic [1:0]  status,
	output logic [10:0] remaining_len,
	output logic [4:0]  group_count
);
	import rpcac_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;
	logic        flavor_null_s1;
	logic [10:0] avail_len_s1;
	logic        adv;
	res_t        res;
	res_t        out_q;
	logic        out_valid_q;

	assign adv        = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			word_s1        <= word;
			first_s1       <= first;
			flavor_null_s1 <= flavor_null;
			avail_len_s1   <= avail_len;
		end
	end

	rpcac_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.word        (word_s1),
		.first       (first_s1),
		.flavor_null (flavor_null_s1),
		.avail_len   (avail_len_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_q <= res;
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = out_q.kind;
	assign value         = out_q.value;
	assign status        = out_q.status;
	assign remaining_len = out_q.remaining_len;
	assign group_count   = out_q.group_count;

endmodule

// ===== tb/sv/rpc_auth_credential_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// RPC credential parser testbench
// Sends Unix-style and null credentials word by word with random idling
// on both channels. Each accepted word runs through a local parser model,
// and every result is checked field by field against the expected queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpc_auth_credential_parser_core_tb;
	import rpcac_pkg::*;

	localparam int unsigned QUIET_LIMIT    = 1000;
	localparam int unsigned RANDOM_WORDS   = 450;
	localparam int unsigned CALM_TAIL      = 100;
	localparam int unsigned NAME_WORD_CAP  = 66;
	localparam int unsigned GROUP_WORD_CAP = 18;

	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		status_t     status;
		logic [10:0] remaining_len;
		logic [4:0]  group_count;
	} cred_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [31:0] word = '0;
	logic        first = 1'b0;
	logic        flavor_null = 1'b0;
	logic [10:0] avail_len = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] value;
	logic [1:0]  status;
	logic [10:0] remaining_len;
	logic [4:0]  group_count;

	cred_result_t pending_results[$];
	cred_result_t oldest;
	logic [31:0]  cred_words[$];
	bit           idle_enable = 1'b1;
	int unsigned  words_sent = 0;
	int unsigned  errors = 0;
	int unsigned  stall_left = 0;
	int unsigned  quiet_cycles = 0;

	// Parser state of the local model.
	phase_t      cur_phase = PH_IDLE;
	longint      words_avail = 0;
	longint      name_skip = 0;
	longint      groups_todo = 0;
	int unsigned groups_done = 0;

	rpc_auth_credential_parser_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.word         (word),
		.first        (first),
		.flavor_null  (flavor_null),
		.avail_len    (avail_len),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.value        (value),
		.status       (status),
		.remaining_len(remaining_len),
		.group_count  (group_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void post_verdict(input status_t s);
		cred_result_t r;
		r.kind = KIND_VERDICT;
		r.value = '0;
		r.status = s;
		r.remaining_len = (s == ST_OK) ? 11'(words_avail) : '0;
		r.group_count = 5'(groups_done);
		cur_phase = PH_IDLE;
		pending_results.push_back(r);
	endfunction

	function automatic void post_id(input kind_t k, input logic [31:0] v);
		cred_result_t r;
		r.kind = k;
		r.value = v;
		r.status = ST_OK;
		r.remaining_len = '0;
		r.group_count = '0;
		pending_results.push_back(r);
	endfunction

	function automatic void parse_credential_word(input logic [31:0] w, input bit is_first,
			input bit is_null, input logic [10:0] av);
		longint n;
		longint avl;
		if (is_first) begin
			avl = (av > MAX_BUFFER_WORDS) ? longint'(MAX_BUFFER_WORDS) : longint'(av);
			groups_done = 0;
			groups_todo = 0;
			name_skip = 0;
			words_avail = 0;
			if (avl < longint'(MIN_AVAIL_WORDS)) begin
				post_verdict(ST_GARBAGE);
				return;
			end
			words_avail = avl - longint'(MIN_AVAIL_WORDS);
			if (is_null) begin
				if (w != 0) begin
					post_verdict(ST_BADCRED);
					return;
				end
				cur_phase = PH_VFL;
			end else begin
				cur_phase = PH_STAMP;
			end
			return;
		end
		case (cur_phase)
			PH_STAMP: cur_phase = PH_MLEN;
			PH_MLEN: begin
				n = (longint'(w) + 3) >>> 2;
				if (n > longint'(MAX_NAME_WORDS) || n + longint'(NAME_TAIL_WORDS) > words_avail) begin
					post_verdict(ST_BADCRED);
					return;
				end
				words_avail -= n + longint'(NAME_TAIL_WORDS);
				name_skip = n;
				cur_phase = (n != 0) ? PH_NAME : PH_UID;
			end
			PH_NAME: begin
				name_skip--;
				if (name_skip == 0)
					cur_phase = PH_UID;
			end
			PH_UID: begin
				cur_phase = PH_GID;
				post_id(KIND_UID, w);
			end
			PH_GID: begin
				cur_phase = PH_GLEN;
				post_id(KIND_GID, w);
			end
			PH_GLEN: begin
				if (longint'(w) > longint'(MAX_GROUPS) ||
						longint'(w) + longint'(GROUP_TAIL_WORDS) > words_avail) begin
					post_verdict(ST_BADCRED);
					return;
				end
				words_avail -= longint'(w) + longint'(GROUP_TAIL_WORDS);
				groups_todo = longint'(w);
				groups_done = 0;
				cur_phase = (w != 0) ? PH_GRP : PH_VFL;
			end
			PH_GRP: begin
				groups_done++;
				groups_todo--;
				if (groups_todo == 0)
					cur_phase = PH_VFL;
				post_id(KIND_GROUP, w);
			end
			PH_VFL: begin
				if (w != 0)
					post_verdict(ST_BADVERF);
				else
					cur_phase = PH_VLEN;
			end
			PH_VLEN: begin
				if (w != 0)
					post_verdict(ST_BADVERF);
				else
					post_verdict(ST_OK);
			end
			default: cur_phase = PH_IDLE;
		endcase
	endfunction

	// Fills the credential words of a Unix-style credential. Name and group words
	// are capped, since past an oversized length the block ignores them anyway.
	function automatic void build_unix(input logic [31:0] name_len, input logic [31:0] uid,
			input logic [31:0] gid, input logic [31:0] glen, input logic [31:0] vfl,
			input logic [31:0] vlen);
		longint n;
		longint g;
		n = (longint'(name_len) + 3) >>> 2;
		if (n > NAME_WORD_CAP)
			n = NAME_WORD_CAP;
		g = (longint'(glen) > GROUP_WORD_CAP) ? longint'(GROUP_WORD_CAP) : longint'(glen);
		cred_words.delete();
		cred_words.push_back($urandom());
		cred_words.push_back($urandom());
		cred_words.push_back(name_len);
		for (longint i = 0; i < n; i++)
			cred_words.push_back($urandom());
		cred_words.push_back(uid);
		cred_words.push_back(gid);
		cred_words.push_back(glen);
		for (longint i = 0; i < g; i++)
			cred_words.push_back($urandom());
		cred_words.push_back(vfl);
		cred_words.push_back(vlen);
	endfunction

	function automatic void build_null(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2);
		cred_words.delete();
		cred_words.push_back(w0);
		cred_words.push_back(w1);
		cred_words.push_back(w2);
	endfunction

	task automatic send_word(input logic [31:0] w, input bit is_first, input bit is_null,
			input logic [10:0] av);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		word <= w;
		first <= is_first;
		flavor_null <= is_null;
		avail_len <= av;
		do @(posedge clk); while (!item_ready);
		parse_credential_word(w, is_first, is_null, av);
		words_sent++;
	endtask

	// Sends the first count credential words, or all of them when count is zero.
	// Flavor and length are random on the words that do not open a credential.
	task automatic send_cred(input bit is_null, input logic [10:0] av, input int unsigned count);
		int unsigned total;
		total = (count == 0 || count > cred_words.size()) ? cred_words.size() : count;
		for (int unsigned i = 0; i < total; i++) begin
			if (i == 0)
				send_word(cred_words[i], 1'b1, is_null, av);
			else
				send_word(cred_words[i], 1'b0, 1'($urandom()), 11'($urandom()));
		end
	endtask

	task automatic send_stray(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_word($urandom(), 1'b0, 1'($urandom()), 11'($urandom()));
	endtask

	task automatic test_unix_credentials();
		build_unix(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd8, 0);
		build_unix(32'd5, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 0);
		build_unix(32'd256, $urandom(), $urandom(), 32'd16, 32'd0, 32'd0);
		send_cred(1'b0, 11'd2047, 0);
	endtask

	task automatic test_short_buffer();
		build_unix(32'd0, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd0, 1);
		send_cred(1'b0, 11'd2, 1);
		send_cred(1'b0, 11'd3, 3);
		build_null(32'hFFFF_FFFF, 32'd0, 32'd0);
		send_cred(1'b1, 11'd1, 1);
	endtask

	task automatic test_name_limits();
		build_unix(32'd257, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 3);
		build_unix(32'hFFFF_FFFF, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 3);
		build_unix(32'hFFFF_FFFD, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 3);
		build_unix(32'd8, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0);
		send_cred(1'b0, 11'd7, 3);
	endtask

	task automatic test_group_limits();
		build_unix(32'd0, 32'd7, 32'd9, 32'd17, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 6);
		build_unix(32'd0, 32'd7, 32'd9, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 6);
		build_unix(32'd0, 32'd7, 32'd9, 32'hFFFF_FFFE, 32'd0, 32'd0);
		send_cred(1'b0, 11'd1024, 6);
		build_unix(32'd4, 32'd7, 32'd9, 32'd2, 32'd0, 32'd0);
		send_cred(1'b0, 11'd10, 7);
	endtask

	task automatic test_verifier();
		build_unix(32'd0, 32'd3, 32'd4, 32'd1, 32'd1, 32'd0);
		send_cred(1'b0, 11'd20, 0);
		build_unix(32'd0, 32'd3, 32'd4, 32'd0, 32'd0, 32'h8000_0000);
		send_cred(1'b0, 11'd20, 0);
	endtask

	task automatic test_auth_null();
		build_null(32'd0, 32'd0, 32'd0);
		send_cred(1'b1, 11'd3, 0);
		send_cred(1'b1, 11'd1024, 0);
		build_null(32'd1, 32'd0, 32'd0);
		send_cred(1'b1, 11'd3, 0);
		build_null(32'd0, 32'h0000_0100, 32'd0);
		send_cred(1'b1, 11'd50, 0);
		build_null(32'd0, 32'd0, 32'hFFFF_FFFF);
		send_cred(1'b1, 11'd50, 0);
	endtask

	task automatic test_stray_and_restart();
		send_stray(3);
		build_unix(32'd3, 32'd11, 32'd12, 32'd2, 32'd0, 32'd0);
		send_cred(1'b0, 11'd100, 5);
		send_cred(1'b0, 11'd100, 0);
		send_stray(2);
	endtask

	task automatic random_credential();
		int unsigned pick;
		logic [31:0] name_len;
		logic [31:0] glen;
		logic [31:0] vfl;
		logic [31:0] vlen;
		longint      needed;
		logic [10:0] av;
		int unsigned cut;
		if ($urandom_range(0, 99) < 8)
			send_stray($urandom_range(1, 3));
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			build_null(($urandom_range(0, 4) == 0) ? $urandom() : 32'd0,
				($urandom_range(0, 6) == 0) ? $urandom() : 32'd0,
				($urandom_range(0, 6) == 0) ? $urandom() : 32'd0);
			av = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 3)) :
				11'($urandom_range(0, 2047));
			send_cred(1'b1, av, cut);
			return;
		end
		pick = $urandom_range(0, 9);
		name_len = (pick < 8) ? $urandom_range(0, 40) :
			(pick == 8) ? $urandom_range(200, 280) : $urandom();
		pick = $urandom_range(0, 9);
		glen = (pick < 8) ? $urandom_range(0, 16) :
			(pick == 8) ? $urandom_range(17, 20) : $urandom();
		vfl = ($urandom_range(0, 9) == 0) ? $urandom() : 32'd0;
		vlen = ($urandom_range(0, 9) == 0) ? $urandom() : 32'd0;
		build_unix(name_len, $urandom(), $urandom(), glen, vfl, vlen);
		needed = cred_words.size() + 5;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			av = 11'(needed + $urandom_range(0, 40));
		else if (pick < 85)
			av = 11'($urandom_range(0, needed));
		else if (pick < 95)
			av = 11'($urandom_range(1025, 2047));
		else
			av = 11'($urandom_range(0, 2));
		send_cred(1'b0, av, cut);
	endtask

	task automatic test_random_credentials();
		int unsigned start;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			if (words_sent - start + CALM_TAIL >= RANDOM_WORDS)
				idle_enable = 1'b0;
			else
				idle_enable = ($urandom_range(0, 3) != 0);
			random_credential();
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d value %0h status %0d", kind, value, status);
				errors++;
			end else begin
				oldest = pending_results.pop_front();
				if (kind !== oldest.kind) begin
					$error("kind: expected %0d, actual %0d", oldest.kind, kind);
					errors++;
				end
				if (value !== oldest.value) begin
					$error("value: expected %0h, actual %0h", oldest.value, value);
					errors++;
				end
				if (status !== oldest.status) begin
					$error("status: expected %0d, actual %0d", oldest.status, status);
					errors++;
				end
				if (remaining_len !== oldest.remaining_len) begin
					$error("remaining_len: expected %0d, actual %0d",
						oldest.remaining_len, remaining_len);
					errors++;
				end
				if (group_count !== oldest.group_count) begin
					$error("group_count: expected %0d, actual %0d",
						oldest.group_count, group_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unix_credentials();
		test_short_buffer();
		test_name_limits();
		test_group_limits();
		test_verifier();
		test_auth_null();
		test_stray_and_restart();
		test_random_credentials();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
